/* rtl/vlrm_pkg.sv */
`timescale 1ns / 1ps

package vlrm_pkg;

    localparam int unsigned COUNT_BITS_DEF    = 24;
    localparam int unsigned RATIO_DIVISOR_DEF = 1000;

    localparam int unsigned PIX_BITS       = 8;
    localparam int unsigned DIV_BITS       = 16;
    localparam int unsigned OUT_COUNT_BITS = 24;
    localparam int unsigned TOTAL_BITS     = 32;
    localparam int unsigned ADDR_BITS      = 4;
    localparam int unsigned APB_DATA_BITS  = 32;
    localparam int unsigned IN_DATA_BITS   = 4 * PIX_BITS;
    localparam int unsigned IN_USER_BITS   = 2;
    localparam int unsigned OUT_DATA_BITS  = 6 * PIX_BITS + 3 * OUT_COUNT_BITS + TOTAL_BITS;
    localparam int unsigned OUT_USER_BITS  = 2;

    localparam logic [PIX_BITS-1:0] LEGAL_LOW_RST  = 8'd16;
    localparam logic [PIX_BITS-1:0] LEGAL_HIGH_RST = 8'd235;
    localparam logic [PIX_BITS-1:0] EXC_LOW_RST    = 8'd17;
    localparam logic [PIX_BITS-1:0] EXC_HIGH_RST   = 8'd234;
    localparam logic [PIX_BITS-1:0] PIX_MIN_RST    = 8'd255;
    localparam logic [PIX_BITS-1:0] PIX_MAX_RST    = 8'd0;

    typedef enum logic [1:0] {
        REG_LEGAL_LOW  = 2'd0,
        REG_LEGAL_HIGH = 2'd1,
        REG_EXC_LOW    = 2'd2,
        REG_EXC_HIGH   = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        VERDICT_FULL_RANGE    = 2'd0,
        VERDICT_LEGAL_FULL    = 2'd1,
        VERDICT_LEGAL_LIMITED = 2'd2
    } t_verdict;

    typedef struct packed {
        logic [PIX_BITS-1:0] legal_low;
        logic [PIX_BITS-1:0] legal_high;
        logic [PIX_BITS-1:0] exc_low;
        logic [PIX_BITS-1:0] exc_high;
    } t_cfg;

    typedef struct packed {
        logic [PIX_BITS-1:0] luma_min;
        logic [PIX_BITS-1:0] luma_max;
        logic [PIX_BITS-1:0] cb_min;
        logic [PIX_BITS-1:0] cb_max;
        logic [PIX_BITS-1:0] cr_min;
        logic [PIX_BITS-1:0] cr_max;
    } t_range;

endpackage

/* rtl/vlrm_regs.sv */
`timescale 1ns / 1ps

module vlrm_regs
    import vlrm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_BITS-1:0]     paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output t_cfg                     o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[ADDR_BITS-1:2]);
    assign w_wr   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.legal_low  <= LEGAL_LOW_RST;
            r_cfg.legal_high <= LEGAL_HIGH_RST;
            r_cfg.exc_low    <= EXC_LOW_RST;
            r_cfg.exc_high   <= EXC_HIGH_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_LEGAL_LOW:  r_cfg.legal_low  <= pwdata[PIX_BITS-1:0];
                REG_LEGAL_HIGH: r_cfg.legal_high <= pwdata[PIX_BITS-1:0];
                REG_EXC_LOW:    r_cfg.exc_low    <= pwdata[PIX_BITS-1:0];
                REG_EXC_HIGH:   r_cfg.exc_high   <= pwdata[PIX_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_LEGAL_LOW:  prdata = APB_DATA_BITS'(r_cfg.legal_low);
            REG_LEGAL_HIGH: prdata = APB_DATA_BITS'(r_cfg.legal_high);
            REG_EXC_LOW:    prdata = APB_DATA_BITS'(r_cfg.exc_low);
            REG_EXC_HIGH:   prdata = APB_DATA_BITS'(r_cfg.exc_high);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

    a_wr_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr && (w_idx == REG_LEGAL_LOW) |=> r_cfg.legal_low == $past(pwdata[PIX_BITS-1:0]))
        else $error("legal_low write lost");

endmodule

/* rtl/vlrm_accum.sv */
`timescale 1ns / 1ps

module vlrm_accum
    import vlrm_pkg::*;
#(
    parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg                    i_cfg,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [IN_DATA_BITS-1:0] s_axis_tdata,
    input  logic [IN_USER_BITS-1:0] s_axis_tuser,
    input  logic                    s_axis_tlast,
    input  logic                    i_snap_ready,
    output logic                    o_push,
    output t_range                  o_range,
    output logic [COUNT_BITS-1:0]   o_below,
    output logic [COUNT_BITS-1:0]   o_above,
    output logic [COUNT_BITS-1:0]   o_samples,
    output logic [TOTAL_BITS-1:0]   o_total
);

    localparam int unsigned CW1 = COUNT_BITS + 1;
    localparam int unsigned TW1 = TOTAL_BITS + 1;

    // input register
    logic                r_in_valid;
    logic [PIX_BITS-1:0] r_cb, r_y0, r_cr, r_y1;
    logic                r_fs, r_ls, r_fe;

    // running statistics
    t_range              r_range, n_range;
    logic [COUNT_BITS-1:0] r_below, n_below;
    logic [COUNT_BITS-1:0] r_above, n_above;
    logic [COUNT_BITS-1:0] r_samples, n_samples;
    logic [TOTAL_BITS-1:0] r_total, n_total;
    logic                r_odd, n_odd;

    logic w_accept, w_consume;

    function automatic logic [COUNT_BITS-1:0] sat_add(logic [COUNT_BITS-1:0] a, logic [1:0] b);
        logic [COUNT_BITS:0] s;
        s = {1'b0, a} + CW1'(b);
        return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
    endfunction

    function automatic logic [PIX_BITS-1:0] min2(logic [PIX_BITS-1:0] a, logic [PIX_BITS-1:0] b);
        return (b < a) ? b : a;
    endfunction

    function automatic logic [PIX_BITS-1:0] max2(logic [PIX_BITS-1:0] a, logic [PIX_BITS-1:0] b);
        return (b > a) ? b : a;
    endfunction

    // hold a frame-end item until the snapshot stage can take it
    assign w_consume     = r_in_valid && (!r_fe || i_snap_ready);
    assign s_axis_tready = !r_in_valid || w_consume;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cb <= s_axis_tdata[PIX_BITS-1:0];
            r_y0 <= s_axis_tdata[2*PIX_BITS-1:PIX_BITS];
            r_cr <= s_axis_tdata[3*PIX_BITS-1:2*PIX_BITS];
            r_y1 <= s_axis_tdata[4*PIX_BITS-1:3*PIX_BITS];
            r_fs <= s_axis_tuser[0];
            r_ls <= s_axis_tuser[1];
            r_fe <= s_axis_tlast;
        end
    end

    always_comb begin
        t_range                base_range;
        logic [COUNT_BITS-1:0] base_below, base_above, base_samples;
        logic [TOTAL_BITS-1:0] base_total;
        logic [TW1-1:0]        tsum;
        logic [1:0]            below_inc, above_inc;

        if (r_fs) begin
            base_range.luma_min = PIX_MIN_RST;
            base_range.luma_max = PIX_MAX_RST;
            base_range.cb_min   = PIX_MIN_RST;
            base_range.cb_max   = PIX_MAX_RST;
            base_range.cr_min   = PIX_MIN_RST;
            base_range.cr_max   = PIX_MAX_RST;
            base_below   = '0;
            base_above   = '0;
            base_samples = '0;
            base_total   = '0;
            n_odd        = 1'b0;
        end else begin
            base_range   = r_range;
            base_below   = r_below;
            base_above   = r_above;
            base_samples = r_samples;
            base_total   = r_total;
            n_odd        = r_ls ? ~r_odd : r_odd;
        end

        below_inc = {1'b0, r_y0 < i_cfg.legal_low} + {1'b0, r_y1 < i_cfg.legal_low};
        above_inc = {1'b0, r_y0 > i_cfg.legal_high} + {1'b0, r_y1 > i_cfg.legal_high};
        tsum      = {1'b0, base_total} + TW1'(r_y0) + TW1'(r_y1);

        n_range   = base_range;
        n_below   = base_below;
        n_above   = base_above;
        n_samples = base_samples;
        n_total   = base_total;

        // measure even lines only
        if (!n_odd) begin
            n_range.luma_min = min2(min2(base_range.luma_min, r_y0), r_y1);
            n_range.luma_max = max2(max2(base_range.luma_max, r_y0), r_y1);
            n_range.cb_min   = min2(base_range.cb_min, r_cb);
            n_range.cb_max   = max2(base_range.cb_max, r_cb);
            n_range.cr_min   = min2(base_range.cr_min, r_cr);
            n_range.cr_max   = max2(base_range.cr_max, r_cr);
            n_below   = sat_add(base_below, below_inc);
            n_above   = sat_add(base_above, above_inc);
            n_samples = sat_add(base_samples, 2'd2);
            n_total   = tsum[TOTAL_BITS] ? {TOTAL_BITS{1'b1}} : tsum[TOTAL_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range.luma_min <= PIX_MIN_RST;
            r_range.luma_max <= PIX_MAX_RST;
            r_range.cb_min   <= PIX_MIN_RST;
            r_range.cb_max   <= PIX_MAX_RST;
            r_range.cr_min   <= PIX_MIN_RST;
            r_range.cr_max   <= PIX_MAX_RST;
            r_below   <= '0;
            r_above   <= '0;
            r_samples <= '0;
            r_total   <= '0;
            r_odd     <= 1'b0;
        end else if (w_consume) begin
            r_range   <= n_range;
            r_below   <= n_below;
            r_above   <= n_above;
            r_samples <= n_samples;
            r_total   <= n_total;
            r_odd     <= n_odd;
        end
    end

    assign o_push    = w_consume && r_fe;
    assign o_range   = n_range;
    assign o_below   = n_below;
    assign o_above   = n_above;
    assign o_samples = n_samples;
    assign o_total   = n_total;

    a_below_le_samples: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_below <= r_samples)
        else $error("below count ahead of sample count");

    a_frame_start_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_consume && r_fs |=> !r_odd)
        else $error("frame start left odd parity");

    a_samples_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_consume && !r_fs |=> r_samples >= $past(r_samples))
        else $error("sample count went backwards within a frame");

endmodule

/* rtl/vlrm_verdict.sv */
`timescale 1ns / 1ps

module vlrm_verdict
    import vlrm_pkg::*;
#(
    parameter int unsigned COUNT_BITS    = COUNT_BITS_DEF,
    parameter int unsigned RATIO_DIVISOR = RATIO_DIVISOR_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cfg                     i_cfg,
    input  logic                     i_push,
    output logic                     o_snap_ready,
    input  t_range                   i_range,
    input  logic [COUNT_BITS-1:0]    i_below,
    input  logic [COUNT_BITS-1:0]    i_above,
    input  logic [COUNT_BITS-1:0]    i_samples,
    input  logic [TOTAL_BITS-1:0]    i_total,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
    output logic [OUT_USER_BITS-1:0] m_axis_tuser
);

    localparam int unsigned          PW  = COUNT_BITS + DIV_BITS;
    localparam logic [DIV_BITS-1:0]  DIV = DIV_BITS'(RATIO_DIVISOR);

    logic                  r_snap_valid;
    t_range                r_s_range;
    logic [COUNT_BITS-1:0] r_s_below, r_s_above, r_s_samples;
    logic [TOTAL_BITS-1:0] r_s_total;

    logic                     r_out_valid;
    logic [OUT_DATA_BITS-1:0] r_out_data;
    t_verdict                 r_out_verdict, n_verdict;

    logic          w_out_ready, w_snap_move;
    logic [PW-1:0] w_below_prod, w_above_prod;
    logic          w_over, w_excursion;

    assign w_out_ready  = !r_out_valid || m_axis_tready;
    assign w_snap_move  = r_snap_valid && w_out_ready;
    assign o_snap_ready = !r_snap_valid || w_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (i_push) begin
            r_snap_valid <= 1'b1;
        end else if (w_snap_move) begin
            r_snap_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_s_range   <= i_range;
            r_s_below   <= i_below;
            r_s_above   <= i_above;
            r_s_samples <= i_samples;
            r_s_total   <= i_total;
        end
    end

    // count > floor(samples / D) is the same test as count * D > samples
    assign w_below_prod = PW'(r_s_below) * PW'(DIV);
    assign w_above_prod = PW'(r_s_above) * PW'(DIV);
    assign w_over       = (w_below_prod > PW'(r_s_samples)) || (w_above_prod > PW'(r_s_samples));
    assign w_excursion  = (r_s_range.luma_min <= i_cfg.exc_low) &&
                          (r_s_range.luma_max >= i_cfg.exc_high);

    always_comb begin
        if (w_over) begin
            n_verdict = VERDICT_FULL_RANGE;
        end else if (w_excursion) begin
            n_verdict = VERDICT_LEGAL_FULL;
        end else begin
            n_verdict = VERDICT_LEGAL_LIMITED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= r_snap_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_snap_move) begin
            r_out_verdict <= n_verdict;
            r_out_data    <= {r_s_total,
                              OUT_COUNT_BITS'(r_s_samples),
                              OUT_COUNT_BITS'(r_s_above),
                              OUT_COUNT_BITS'(r_s_below),
                              r_s_range.cr_max,
                              r_s_range.cr_min,
                              r_s_range.cb_max,
                              r_s_range.cb_min,
                              r_s_range.luma_max,
                              r_s_range.luma_min};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_verdict;

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_snap_ready)
        else $error("snapshot overwritten before it moved on");

    a_snap_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_snap_move |=> r_out_valid)
        else $error("snapshot moved but no result shown");

endmodule

/* rtl/video_legal_range_monitor.sv */
`timescale 1ns / 1ps

// A frame-end item's statistics pass from the input register to the snapshot and output registers.
// Throughput: one macropixel item per cycle, sustained, on every cycle the output is not stalled.
// While a result is stalled one more waits in the snapshot register; the next frame-end item
// then holds in the input register and stalls the input. Items before it keep flowing.
// Reset (i_rst_n, synchronous, active low): registers return to 16/235/17/234, statistics
// clear, line parity goes even, and both stream sides drop their valid flags.
module video_legal_range_monitor
    import vlrm_pkg::*;
#(
    parameter int unsigned COUNT_BITS    = COUNT_BITS_DEF,
    parameter int unsigned RATIO_DIVISOR = RATIO_DIVISOR_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    // configuration port, registers at byte addresses 0, 4, 8, 12
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_BITS-1:0]     paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,

    // macropixel input
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,  // cb[7:0], luma0[15:8], cr[23:16], luma1[31:24]
    input  logic [IN_USER_BITS-1:0]  s_axis_tuser,  // frame_start[0], line_start[1]
    input  logic                     s_axis_tlast,  // frame_end

    // per-frame statistics output
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // luma_min[7:0], luma_max[15:8], cb_min[23:16], cb_max[31:24], cr_min[39:32],
    // cr_max[47:40], below_count[71:48], above_count[95:72], sample_count[119:96],
    // luma_total[151:120]
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
    output logic [OUT_USER_BITS-1:0] m_axis_tuser   // verdict[1:0]
);

    t_cfg                  w_cfg;
    logic                  w_push, w_snap_ready;
    t_range                w_range;
    logic [COUNT_BITS-1:0] w_below, w_above, w_samples;
    logic [TOTAL_BITS-1:0] w_total;

    // Threshold registers; write them only while the stream is idle (the block does not enforce this).
    vlrm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Input register plus the running statistics. Each item on an even line
    // updates min/max, the saturating counts and the luma sum in one pass; a
    // frame-end item also hands its updated statistics to the verdict stage.
    vlrm_accum #(
        .COUNT_BITS (COUNT_BITS)
    ) u_accum (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .i_snap_ready  (w_snap_ready),
        .o_push        (w_push),
        .o_range       (w_range),
        .o_below       (w_below),
        .o_above       (w_above),
        .o_samples     (w_samples),
        .o_total       (w_total)
    );

    // Snapshot register, then the range verdict (one constant multiply and
    // compare per count) into the output register.
    vlrm_verdict #(
        .COUNT_BITS    (COUNT_BITS),
        .RATIO_DIVISOR (RATIO_DIVISOR)
    ) u_verdict (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_push        (w_push),
        .o_snap_ready  (w_snap_ready),
        .i_range       (w_range),
        .i_below       (w_below),
        .i_above       (w_above),
        .i_samples     (w_samples),
        .i_total       (w_total),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
